/* design/isa_pkg.sv */
// shared types, sizes and codes for the indexed shift array
// used by isa_cell, isa_rd_tree and indexed_shift_array_core
package isa_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 7;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP_SIZE  = 8;
  localparam int NGROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [2:0] KIND_INSERT   = 3'd0;
  localparam logic [2:0] KIND_REMOVE   = 3'd1;
  localparam logic [2:0] KIND_PUSH     = 3'd2;
  localparam logic [2:0] KIND_POP      = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_WRITE    = 3'd5;
  localparam logic [2:0] KIND_CLEAR    = 3'd6;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  position;
    logic [31:0] value_in;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [6:0]  element_total;
  } out_rsp_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             load;
    logic [CMP_W-1:0] addr;
    logic [CMP_W-1:0] rd_addr;
    val_t             data;
  } cell_ctl_t;

endpackage

/* design/indexed_shift_array_core.sv */
// top level of the indexed shift array: control, row of cells, read tree
// depends on isa_pkg, isa_cell and isa_rd_tree
//
// usage:
//   in_valid/in_ready carry one request (kind, position, value_in) that
//   inserts, removes, pushes, pops, reads, writes or clears the array.
//   out_valid/out_ready return one response per request: status, the
//   value read (zero unless a read succeeded) and the element count.
// pipeline: the edge that takes a request updates the cell row, the first
//   read-tree level and the middle stage; the final read or feeds the output
//   register, which takes the response when the middle stage advances.
// throughput: one request per cycle unless out_ready stalls; every cell shifts
//   or loads in the same cycle, so an insert or remove anywhere costs no more than a read.
// stall: while out_ready is low the response holds, one more request is
//   taken into the middle stage, then in_ready drops until space frees.
// reset: rst_n low for one clock empties the array and drops both valids;
//   entries are not cleared, since only entries below the count are read.
module indexed_shift_array_core import isa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [1:0]       s1_status_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_rd_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_rsp_t         out_rsp_r;

  logic             in_fire;
  logic             s1_adv;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cap_c;
  logic             not_full;
  logic             pos_valid;
  logic [1:0]       status;
  logic             rd_ok;
  cell_ctl_t        ctl;
  val_t             cell_val [CAPACITY];
  val_t             cell_rd  [CAPACITY];
  val_t             tree_val;

  assign in_fire = in_valid && in_ready;
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign pos       = CMP_W'(in_req.position);
  assign cnt_ext   = CMP_W'(cnt_r);
  assign cap_c     = CMP_W'(CAPACITY);
  assign not_full  = (cnt_ext < cap_c);
  assign pos_valid = (pos < cnt_ext);

  // decode the request into status, new count and cell commands
  always_comb begin
    status         = ST_OK;
    cnt_nxt        = cnt_r;
    rd_ok          = 1'b0;
    ctl            = '0;
    ctl.addr       = pos;
    ctl.rd_addr    = pos;
    ctl.data       = VALUE_WIDTH'(in_req.value_in);
    case (in_req.kind)
      KIND_INSERT: begin
        if (pos > cnt_ext) begin
          status = ST_BAD_INDEX;
        end else if (!not_full) begin
          status = ST_FULL;
        end else begin
          ctl.shift_up = in_fire;
          ctl.load     = in_fire;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (!pos_valid) begin
          status = ST_BAD_INDEX;
        end else begin
          ctl.shift_down = in_fire;
          cnt_nxt        = cnt_r - 1'b1;
        end
      end
      KIND_PUSH: begin
        if (!not_full) begin
          status = ST_FULL;
        end else begin
          ctl.addr = cnt_ext;
          ctl.load = in_fire;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      KIND_POP: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      KIND_READ: begin
        if (!pos_valid) begin
          status = ST_BAD_INDEX;
        end else begin
          rd_ok = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (!pos_valid) begin
          status = ST_BAD_INDEX;
        end else begin
          ctl.load = in_fire;
        end
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      val_t left_v;
      val_t right_v;
      if (i == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_left
        assign left_v = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_right
        assign right_v = cell_val[i+1];
      end
      isa_cell u_cell (
        .clk       (clk),
        .cell_idx  (CMP_W'(i)),
        .ctl       (ctl),
        .left_val  (left_v),
        .right_val (right_v),
        .val       (cell_val[i]),
        .rd_val    (cell_rd[i])
      );
    end
  endgenerate

  isa_rd_tree u_rd_tree (
    .clk    (clk),
    .load   (in_fire),
    .lane   (cell_rd),
    .rd_val (tree_val)
  );

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r <= cnt_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= status;
      s1_cnt_r    <= cnt_nxt;
      s1_rd_r     <= rd_ok;
    end
    if (s1_adv) begin
      out_rsp_r.status        <= s1_status_r;
      out_rsp_r.value_out     <= s1_rd_r ? 32'(tree_val) : 32'd0;
      out_rsp_r.element_total <= 7'(s1_cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= cap_c)
    else $error("element count above capacity");

  a_reject_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (status != ST_OK)) |=> $stable(cnt_r))
    else $error("rejected request changed the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req.kind == KIND_CLEAR)) |=> (cnt_r == '0))
    else $error("clear left elements behind");

  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("middle stage advanced without a response");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule

/* design/isa_cell.sv */
// one storage cell of the shift row: holds one value and takes it from
// its left or right neighbor, the load bus, or keeps it; uses isa_pkg
module isa_cell import isa_pkg::*; (
  input  logic             clk,
  input  logic [CMP_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  val_t             left_val,
  input  val_t             right_val,
  output val_t             val,
  output val_t             rd_val
);

  val_t val_r;
  val_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_up && (cell_idx > ctl.addr)) begin
      val_nxt = left_val;
    end else if (ctl.shift_down && (cell_idx >= ctl.addr)) begin
      val_nxt = right_val;
    end else if (ctl.load && (cell_idx == ctl.addr)) begin
      val_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = (cell_idx == ctl.rd_addr) ? val_r : '0;

endmodule

/* design/isa_rd_tree.sv */
// registered or-tree that collects the one selected cell value
// first level groups cells and registers partial ors; uses isa_pkg
module isa_rd_tree import isa_pkg::*; (
  input  logic clk,
  input  logic load,
  input  val_t lane [CAPACITY],
  output val_t rd_val
);

  val_t part_r   [NGROUPS];
  val_t part_nxt [NGROUPS];

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          part_nxt[g] = part_nxt[g] | lane[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part_r <= part_nxt;
    end
  end

  always_comb begin
    rd_val = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rd_val = rd_val | part_r[g];
    end
  end

endmodule

/* tb/sv/tb_indexed_shift_array_core.sv */
// testbench for indexed_shift_array_core: directed and random request streams,
// each response checked against a behavioral copy of the array kept here
// depends on isa_pkg and the indexed_shift_array_core rtl
module tb_indexed_shift_array_core;
  timeunit 1ns;
  timeprecision 1ps;

  import isa_pkg::*;

  localparam logic [2:0] KIND_NOP = 3'd7;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int EXP_DEPTH    = 16;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  // behavioral copy of the array and the responses still owed
  // owed responses sit in a ring indexed by the running totals
  val_t     array_vals [CAPACITY];
  int       array_count = 0;
  out_rsp_t exp_rsp [EXP_DEPTH];
  int       exp_wr_total = 0;
  int       exp_rd_total = 0;

  int fail_count         = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles       = 0;
  bit grow_phase         = 1'b1;

  always #5 clk = ~clk;

  indexed_shift_array_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // applies one request to the array copy and returns the response it owes
  function automatic out_rsp_t apply_array_op(input in_req_t req);
    out_rsp_t rsp;
    int       p;
    rsp = '0;
    rsp.status = ST_OK;
    p = req.position;
    case (req.kind)
      KIND_INSERT: begin
        if (p > array_count) begin
          rsp.status = ST_BAD_INDEX;
        end else if (array_count >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = array_count; i > p; i--) array_vals[i] = array_vals[i-1];
          array_vals[p] = val_t'(req.value_in);
          array_count++;
        end
      end
      KIND_REMOVE: begin
        if (p >= array_count) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < array_count; i++) array_vals[i] = array_vals[i+1];
          array_count--;
        end
      end
      KIND_PUSH: begin
        if (array_count >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          array_vals[array_count] = val_t'(req.value_in);
          array_count++;
        end
      end
      KIND_POP: begin
        if (array_count == 0) rsp.status = ST_EMPTY;
        else array_count--;
      end
      KIND_READ: begin
        if (p >= array_count) rsp.status = ST_BAD_INDEX;
        else rsp.value_out = 32'(array_vals[p]);
      end
      KIND_WRITE: begin
        if (p >= array_count) rsp.status = ST_BAD_INDEX;
        else array_vals[p] = val_t'(req.value_in);
      end
      KIND_CLEAR: begin
        array_count = 0;
      end
      default: begin
      end
    endcase
    rsp.element_total = 7'(array_count);
    return rsp;
  endfunction

  // valid stays up between back-to-back requests; it drops only in a gap
  task automatic issue_request(input logic [2:0] kind, input int pos,
                               input logic [31:0] val);
    in_req_t req;
    req.kind     = kind;
    req.position = 7'(pos);
    req.value_in = val;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    exp_rsp[4'(exp_wr_total)] = apply_array_op(req);
    exp_wr_total++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_wr_total != exp_rd_total);
  endtask

  task automatic test_empty_array();
    issue_request(KIND_READ,   0,   32'h0000_0001);
    issue_request(KIND_REMOVE, 0,   32'h0);
    issue_request(KIND_POP,    0,   32'h0);
    issue_request(KIND_WRITE,  0,   32'hFFFF_FFFF);
    // insert past the end is refused even on an empty array
    issue_request(KIND_INSERT, 1,   32'h1234_5678);
    issue_request(KIND_REMOVE, 127, 32'h0);
    issue_request(KIND_NOP,    0,   32'hFFFF_FFFF);
    issue_request(KIND_CLEAR,  127, 32'h0);
  endtask

  task automatic test_basic_ops();
    issue_request(KIND_INSERT, 0, 32'h0000_0000);
    issue_request(KIND_PUSH,   0, 32'hFFFF_FFFF);
    issue_request(KIND_INSERT, 1, 32'hA5A5_A5A5);
    issue_request(KIND_INSERT, 3, 32'h5A5A_5A5A);
    for (int i = 0; i < 4; i++) issue_request(KIND_READ, i, 32'h0);
    issue_request(KIND_WRITE,  2, 32'h1234_5678);
    issue_request(KIND_REMOVE, 1, 32'h0);
    issue_request(KIND_READ,   1, 32'h0);
    issue_request(KIND_POP,    0, 32'h0);
    issue_request(KIND_READ,   2, 32'h0);
    issue_request(KIND_NOP,    127, 32'h0);
    issue_request(KIND_CLEAR,  0, 32'h0);
    issue_request(KIND_READ,   0, 32'h0);
  endtask

  task automatic test_full_array();
    issue_request(KIND_CLEAR, 0, 32'h0);
    repeat (CAPACITY) issue_request(KIND_PUSH, 0, $urandom);
    issue_request(KIND_PUSH,   0,  32'hDEAD_BEEF);
    issue_request(KIND_INSERT, 64, 32'hDEAD_BEEF);
    // index check wins over the full check
    issue_request(KIND_INSERT, 65, 32'hDEAD_BEEF);
    issue_request(KIND_INSERT, 0,  32'hDEAD_BEEF);
    issue_request(KIND_READ,   63, 32'h0);
    issue_request(KIND_READ,   64, 32'h0);
    issue_request(KIND_WRITE,  63, 32'hFFFF_FFFF);
    issue_request(KIND_READ,   63, 32'h0);
    issue_request(KIND_REMOVE, 0,  32'h0);
    issue_request(KIND_INSERT, 63, 32'h0000_0001);
    issue_request(KIND_INSERT, 0,  32'h0000_0002);
    issue_request(KIND_READ,   0,  32'h0);
    issue_request(KIND_POP,    0,  32'h0);
    issue_request(KIND_REMOVE, 62, 32'h0);
    issue_request(KIND_READ,   62, 32'h0);
  endtask

  // count drifts up and down so both the empty and the full ends get hit
  task automatic test_random_ops(input int n_req, input int idle_pct, input int stall_pct);
    logic [2:0]  kind;
    logic [31:0] val;
    int          pos;
    int          pick;
    bit          toward;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n_req) begin
      if (array_count == CAPACITY && $urandom_range(7) == 0) grow_phase = 1'b0;
      else if (array_count == 0 && $urandom_range(7) == 0) grow_phase = 1'b1;
      else if ($urandom_range(59) == 0) grow_phase = ~grow_phase;

      pick = $urandom_range(99);
      toward = (pick < 86) ? grow_phase : ~grow_phase;
      if (pick < 2) kind = KIND_CLEAR;
      else if (pick < 4) kind = KIND_NOP;
      else if (pick < 24) kind = KIND_READ;
      else if (pick < 36) kind = KIND_WRITE;
      else if (toward) kind = $urandom_range(1) ? KIND_INSERT : KIND_PUSH;
      else kind = $urandom_range(1) ? KIND_REMOVE : KIND_POP;

      pick = $urandom_range(99);
      if (pick < 80) begin
        if (kind == KIND_INSERT) pos = $urandom_range(array_count);
        else pos = (array_count == 0) ? 0 : $urandom_range(array_count - 1);
      end else if (pick < 90) begin
        pos = array_count + $urandom_range(1);
      end else begin
        pos = $urandom_range(127);
      end

      if ($urandom_range(9) == 0) val = $urandom_range(1) ? '1 : '0;
      else val = $urandom;

      issue_request(kind, pos, val);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin : check_rsp
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr_total == exp_rd_total) begin
        $error("response with no request outstanding: %p", out_rsp);
        fail_count++;
      end else begin
        want = exp_rsp[4'(exp_rd_total)];
        exp_rd_total++;
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          fail_count++;
        end
        if (out_rsp.value_out !== want.value_out) begin
          $error("value_out: expected %08h, got %08h", want.value_out, out_rsp.value_out);
          fail_count++;
        end
        if (out_rsp.element_total !== want.element_total) begin
          $error("element_total: expected %0d, got %0d",
                 want.element_total, out_rsp.element_total);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** indexed_shift_array_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_array();
    test_basic_ops();
    test_full_array();
    wait_drained();
    test_random_ops(450, 0, 0);
    wait_drained();
    test_random_ops(450, 73, 0);
    wait_drained();
    test_random_ops(450, 0, 73);
    wait_drained();
    test_random_ops(450, 21, 21);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && exp_wr_total == exp_rd_total) begin
      $display("** indexed_shift_array_core: PASSED **");
    end else begin
      $display("** indexed_shift_array_core: FAILED **");
    end
    $finish;
  end

endmodule
